// ----- rtl/fph_pkg.sv -----
`timescale 1ns / 1ps

package fph_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned LIMIT_W = 10;

  localparam logic [LIMIT_W-1:0] FILL_LIMIT_RST = 10'd512;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  // 64-bit FNV offset basis. The prime is 2^40 + 435 and is applied by shifts and adds.
  localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;

  typedef enum logic [1:0] {
    OC_LOOKUP   = 2'd0,
    OC_INSERTED = 2'd1,
    OC_REPLACED = 2'd2,
    OC_REFUSED  = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_PROBE
  } back_state_e;

  typedef struct packed {
    logic             mode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } job_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    outcome_e         outcome;
  } result_t;

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] data;
  } slot_t;

  // One FNV-1a round: xor in a byte, then multiply by 2^40 + 435 modulo 2^64.
  function automatic logic [63:0] fnv_step(logic [63:0] h, logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
  endfunction

endpackage

// ----- rtl/fph_fifo.sv -----
`timescale 1ns / 1ps

module fph_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/fph_front.sv -----
`timescale 1ns / 1ps

module fph_front #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  fph_pkg::job_t            job_i,
  output logic                     ready_o,
  output logic                     push_o,
  output fph_pkg::job_t            job_o,
  output logic [$clog2(SLOTS)-1:0] home_o,
  input  logic                     q_full_i
);

  localparam int unsigned IDX_W     = $clog2(SLOTS);
  localparam bit          IS_POW2   = ((SLOTS & (SLOTS - 1)) == 0);
  localparam logic [3:0]  HASH_LAST = 4'd3;
  localparam logic [3:0]  LAST      = IS_POW2 ? 4'd3 : 4'd11;
  localparam logic [IDX_W:0] MODULUS = (IDX_W + 1)'(SLOTS);

  logic              busy_q, busy_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [63:0]       h_q, h_d;
  logic [23:0]       k_q, k_d;
  logic [IDX_W-1:0]  r_q, r_d;
  fph_pkg::job_t     job_q, job_d;
  logic              done;

  // Folds eight more hash bits, most significant first, into a remainder below SLOTS.
  function automatic logic [IDX_W-1:0] mod_byte(logic [IDX_W-1:0] r, logic [7:0] b);
    logic [IDX_W:0] t;
    t = {1'b0, r};
    for (int i = 7; i >= 0; i--) begin
      t = {t[IDX_W-1:0], b[i]};
      if (t >= MODULUS) begin
        t = t - MODULUS;
      end
    end
    return t[IDX_W-1:0];
  endfunction

  assign done    = busy_q && (cnt_q == LAST);
  assign push_o  = done && !q_full_i;
  assign ready_o = !busy_q || push_o;
  assign job_o   = job_q;
  assign home_o  = IS_POW2 ? h_q[IDX_W-1:0] : r_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    h_d    = h_q;
    k_d    = k_q;
    r_d    = r_q;
    job_d  = job_q;
    priority if (accept_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      h_d    = fph_pkg::fnv_step(fph_pkg::FNV_BASIS, job_i.key[7:0]);
      k_d    = job_i.key[31:8];
      r_d    = '0;
      job_d  = job_i;
    end else if (push_o) begin
      busy_d = 1'b0;
    end else if (busy_q && (cnt_q < HASH_LAST)) begin
      h_d   = fph_pkg::fnv_step(h_q, k_q[7:0]);
      k_d   = k_q >> 8;
      cnt_d = cnt_q + 1'b1;
    end else if (busy_q && (cnt_q < LAST)) begin
      r_d   = mod_byte(r_q, h_q[63:56]);
      h_d   = h_q << 8;
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q   <= h_d;
    k_q   <= k_d;
    r_q   <= r_d;
    job_q <= job_d;
  end

endmodule

// ----- rtl/fph_back.sv -----
`timescale 1ns / 1ps

module fph_back #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [fph_pkg::LIMIT_W-1:0]         fill_limit_i,
  input  logic                                job_valid_i,
  input  fph_pkg::job_t                       job_i,
  input  logic [$clog2(SLOTS)-1:0]            home_i,
  output logic                                job_pop_o,
  input  logic                                res_full_i,
  output logic                                res_push_o,
  output fph_pkg::result_t                    res_o,
  output logic                                clearing_o
);

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);

  fph_pkg::slot_t       mem_q [SLOTS];
  fph_pkg::slot_t       rdata_q;
  fph_pkg::slot_t       wr_data;
  logic [IDX_W-1:0]     rd_addr, wr_addr;
  logic                 wr_en;

  fph_pkg::back_state_e state_q, state_d;
  logic [IDX_W-1:0]     clr_q, clr_d;
  logic [IDX_W-1:0]     addr_q, addr_d, next_addr;
  logic [IDX_W-1:0]     steps_q, steps_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  fph_pkg::job_t        job_q, job_d;
  logic                 key_match, found_key, room;

  assign next_addr  = (addr_q == IDX_W'(SLOTS - 1)) ? '0 : addr_q + 1'b1;
  assign key_match  = rdata_q.used && (rdata_q.key == job_q.key);
  assign found_key  = key_match;
  assign room       = 32'(cnt_q) < 32'(fill_limit_i);
  assign clearing_o = (state_q == fph_pkg::BK_CLEAR);

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    addr_d     = addr_q;
    steps_d    = steps_q;
    cnt_d      = cnt_q;
    job_d      = job_q;
    rd_addr    = next_addr;
    wr_en      = 1'b0;
    wr_addr    = addr_q;
    wr_data    = '{used: 1'b1, key: job_q.key, data: job_q.value};
    job_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '{hit: 1'b0, read_value: '0, outcome: fph_pkg::OC_LOOKUP};
    unique case (state_q)
      fph_pkg::BK_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == IDX_W'(SLOTS - 1)) begin
          state_d = fph_pkg::BK_IDLE;
        end
      end
      fph_pkg::BK_IDLE: begin
        rd_addr = home_i;
        if (job_valid_i && !res_full_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          addr_d    = home_i;
          steps_d   = '0;
          state_d   = fph_pkg::BK_PROBE;
        end
      end
      fph_pkg::BK_PROBE: begin
        if (!rdata_q.used || found_key || (steps_q == IDX_W'(SLOTS - 1))) begin
          res_push_o = 1'b1;
          state_d    = fph_pkg::BK_IDLE;
          if (job_q.mode == fph_pkg::MODE_LOOKUP) begin
            res_o.hit        = found_key;
            res_o.read_value = found_key ? rdata_q.data : '0;
            res_o.outcome    = fph_pkg::OC_LOOKUP;
          end else if (found_key) begin
            wr_en         = 1'b1;
            res_o.hit     = 1'b1;
            res_o.outcome = fph_pkg::OC_REPLACED;
          end else if (!rdata_q.used && room) begin
            wr_en         = 1'b1;
            cnt_d         = cnt_q + 1'b1;
            res_o.outcome = fph_pkg::OC_INSERTED;
          end else begin
            res_o.outcome = fph_pkg::OC_REFUSED;
          end
        end else begin
          addr_d  = next_addr;
          steps_d = steps_q + 1'b1;
        end
      end
      default: begin
        state_d = fph_pkg::BK_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fph_pkg::BK_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    steps_q <= steps_d;
    job_q   <= job_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= SLOTS)
    else $error("entry count exceeds the table size");

  a_push_from_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> (state_q == fph_pkg::BK_PROBE))
    else $error("result produced outside a probe");

  a_pop_starts_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> (state_q == fph_pkg::BK_PROBE) && (addr_q == $past(home_i)))
    else $error("probe did not start at the home slot");

  a_insert_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && (res_o.outcome == fph_pkg::OC_INSERTED)) |=>
      (cnt_q == $past(cnt_q) + 1'b1))
    else $error("insert did not bump the entry count");

  a_count_only_on_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_push_o && (res_o.outcome == fph_pkg::OC_INSERTED)) |=> $stable(cnt_q))
    else $error("entry count moved without an insert");

endmodule

// ----- rtl/fnv1a_linear_probe_hash_table.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake                        Payload
// -------   ---------  -------------------------------  -----------------------------------
// request   in         push / full, taken: push & !full mode_i, key_i, value_i
// result    out        empty / pop, taken: pop & !empty hit_o, read_value_o, outcome_o
// config    in         cfg_valid_i / cfg_ready_o        cfg_data_i (fill limit)
//
// The front hashes one key byte per cycle and takes a new item only once it is idle or passes
// the last one to the queue; when SLOTS is not a power of two it then reduces the 64-bit hash
// modulo SLOTS a byte at a time. The back checks one slot per probe step, since the slot memory
// returns one registered read per cycle, and takes a new item only from its idle state, once the
// last one is finished. After reset the back sweeps the slot memory to clear the used bits, and
// full stays high for that whole sweep. Configuration writes are taken at any time.
// A two-entry queue sits between front and back, and another holds finished results, so a
// stalled result reader does not at once stop the front from hashing the next items.

module fnv1a_linear_probe_hash_table #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request queue side.
  input  logic                          push,
  output logic                          full,
  input  logic                          mode_i,
  input  logic [fph_pkg::KEY_W-1:0]     key_i,
  input  logic [fph_pkg::VAL_W-1:0]     value_i,
  // Result queue side.
  output logic                          empty,
  input  logic                          pop,
  output logic                          hit_o,
  output logic [fph_pkg::VAL_W-1:0]     read_value_o,
  output logic [1:0]                    outcome_o,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fph_pkg::LIMIT_W-1:0]   cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned JOB_W = $bits(fph_pkg::job_t);
  localparam int unsigned RES_W = $bits(fph_pkg::result_t);

  logic [fph_pkg::LIMIT_W-1:0] fill_limit_q;

  fph_pkg::job_t     in_job;
  logic              accept;
  logic              front_ready, front_push;
  fph_pkg::job_t     front_job;
  logic [IDX_W-1:0]  front_home;

  logic              jq_full, jq_empty, jq_pop;
  fph_pkg::job_t     jq_job;
  logic [IDX_W-1:0]  jq_home;

  logic              clearing;
  logic              rq_full, rq_push;
  fph_pkg::result_t  back_res, rq_res;

  // The fill limit register; the port never pushes back.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_limit_q <= fph_pkg::FILL_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      fill_limit_q <= cfg_data_i;
    end
  end

  // An item is taken only once the front is free and the clearing sweep is over.
  assign full   = !front_ready || clearing;
  assign accept = push && !full;
  assign in_job = '{mode: mode_i, key: key_i, value: value_i};

  fph_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .job_i    (in_job),
    .ready_o  (front_ready),
    .push_o   (front_push),
    .job_o    (front_job),
    .home_o   (front_home),
    .q_full_i (jq_full)
  );

  // Hashed items wait here with their home slot until the back picks them up.
  fph_fifo #(
    .WIDTH (JOB_W + IDX_W),
    .DEPTH (2)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  ({front_job, front_home}),
    .full_o  (jq_full),
    .pop_i   (jq_pop),
    .data_o  ({jq_job, jq_home}),
    .empty_o (jq_empty)
  );

  fph_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fill_limit_i (fill_limit_q),
    .job_valid_i  (!jq_empty),
    .job_i        (jq_job),
    .home_i       (jq_home),
    .job_pop_o    (jq_pop),
    .res_full_i   (rq_full),
    .res_push_o   (rq_push),
    .res_o        (back_res),
    .clearing_o   (clearing)
  );

  // Finished results wait here until the reader pops them.
  fph_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .data_i  (back_res),
    .full_o  (rq_full),
    .pop_i   (pop),
    .data_o  (rq_res),
    .empty_o (empty)
  );

  assign hit_o        = rq_res.hit;
  assign read_value_o = rq_res.read_value;
  assign outcome_o    = rq_res.outcome;

endmodule
